// File: design/ofv_pkg.sv
// Shared constants, types and helper functions of the optical-flow velocity filter.
// Used by the divider and the top level; depends on nothing.
package ofv_pkg;

  localparam int SUM_W      = 24;
  localparam int SCALE_W    = 20;
  localparam int FLOW_NUM_W = SUM_W + SCALE_W;
  localparam int DIV_W      = 64;
  localparam int REM_W      = 33;
  localparam int CNT_W      = 7;

  localparam logic [31:0] RATE_SCALE = 32'd1000000;

  localparam logic [1:0] CFG_GAIN = 2'd0;
  localparam logic [1:0] CFG_TAU  = 2'd1;
  localparam logic [1:0] CFG_WIN  = 2'd2;

  localparam logic [31:0] GAIN_RESET = 32'd5589980;
  localparam logic [19:0] TAU_RESET  = 20'd15915;
  localparam logic [19:0] WIN_RESET  = 20'd10000;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem0;
    logic [DIV_W-1:0] num;
    logic [REM_W-1:0] den;
    logic [CNT_W-1:0] count;
  } div_req_t;

  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic [63:0] lim;
    lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    return (m > lim) ? lim[31:0] : m[31:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s,
                                               input logic [15:0] d);
    logic [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-15){d[15]}}, d};
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

// File: design/optical_flow_velocity_filter.sv
// Top level of the optical-flow velocity filter: window control, sequencer, output register.
// Depends on ofv_pkg, ofv_mul and ofv_div.
//
//   Channel  Direction  Signals                          Item
//   in_      slave      tvalid tready tdata[63:0] tuser  motion sample and timestamp
//   out_     master     tvalid tready tdata[127:0]       filtered velocities and flow rates
//   cfg_     slave      valid ready index[1:0] data[31:0] register write
//
// An item that does not close a window only updates the sums; intake stays ready.
// An item that closes a window stops intake while the sequencer works through each axis in turn:
// two divisions on the shared divider (SUM_W + 20 and 32 quotient bits) and three products on
// the shared multiplier.
// Reset is synchronous and active low; it restores the register defaults and clears sums, filters and control.
// A held result stalls only the final hand-over; the computation runs while out_tready is low.
module optical_flow_velocity_filter
  import ofv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // delta_x[15:0], delta_y[31:16], now_us[63:32]
  input  logic         in_tuser,   // motion_valid
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // filtered_vel_x, filtered_vel_y, flow_rate_x, flow_rate_y
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MFLOW = 4'd1;
  localparam logic [3:0] ST_DFLOW = 4'd2;
  localparam logic [3:0] ST_WFLOW = 4'd3;
  localparam logic [3:0] ST_MVEL  = 4'd4;
  localparam logic [3:0] ST_DIFF  = 4'd5;
  localparam logic [3:0] ST_MLP   = 4'd6;
  localparam logic [3:0] ST_DLP   = 4'd7;
  localparam logic [3:0] ST_WLP   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [31:0]      gain_r;
  logic [19:0]      tau_r;
  logic [19:0]      win_r;
  logic [31:0]      start_r;
  logic             started_r;
  logic [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [31:0]      smooth_x_r, smooth_y_r;
  logic [31:0]      elapsed_r;
  logic [3:0]       state_r;
  logic             axis_r;
  logic             fneg_r;
  logic [31:0]      fmag_r;
  logic             dneg_r;
  logic [31:0]      dmag_r;
  logic [31:0]      flow_x_r, flow_y_r;
  logic [127:0]     out_tdata_r;
  logic             out_tvalid_r;

  logic             in_acc;
  logic [15:0]      delta_x, delta_y;
  logic [31:0]      now_us;
  logic [31:0]      start_eff;
  logic [31:0]      elapsed_c;
  logic [19:0]      win_eff;
  logic             close_c;
  logic [SUM_W-1:0] sum_x_nxt, sum_y_nxt;

  logic [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0] sum_mag;
  logic [31:0]      smooth_sel;
  logic [31:0]      flow_mag_c;
  logic [31:0]      vmag_c;
  logic [31:0]      vel_c;
  logic [32:0]      diff_c;
  logic [32:0]      diff_neg_c;
  logic [31:0]      step_c;
  logic [31:0]      smooth_nxt;

  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod_r;
  div_req_t         div_req;
  logic             div_busy, div_done;
  logic [DIV_W-1:0] div_q;

  assign delta_x = in_tdata[15:0];
  assign delta_y = in_tdata[31:16];
  assign now_us  = in_tdata[63:32];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign start_eff = started_r ? start_r : now_us;
  assign elapsed_c = now_us - start_eff;
  assign win_eff   = (win_r == 20'd0) ? 20'd1 : win_r;
  assign close_c   = elapsed_c >= {12'd0, win_eff};
  assign sum_x_nxt = in_tuser ? sat_sum(sum_x_r, delta_x) : sum_x_r;
  assign sum_y_nxt = in_tuser ? sat_sum(sum_y_r, delta_y) : sum_y_r;

  assign sum_sel    = axis_r ? sum_y_r : sum_x_r;
  assign sum_mag    = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
  assign smooth_sel = axis_r ? smooth_y_r : smooth_x_r;
  assign flow_mag_c = sat_mag(fneg_r, div_q);
  assign vmag_c     = sat_mag(fneg_r, {16'd0, prod_r[63:16]});
  assign vel_c      = fneg_r ? (~vmag_c + 1'b1) : vmag_c;
  assign diff_c     = {vel_c[31], vel_c} - {smooth_sel[31], smooth_sel};
  assign diff_neg_c = ~diff_c + 1'b1;
  assign step_c     = div_q[31:0];
  assign smooth_nxt = dneg_r ? (smooth_sel - step_c) : (smooth_sel + step_c);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    div_req = '0;
    case (state_r)
      ST_MFLOW: begin
        mul_a = 32'(sum_mag);
        mul_b = RATE_SCALE;
      end
      ST_DFLOW: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r << (DIV_W - FLOW_NUM_W);
        div_req.den   = {1'b0, elapsed_r};
        div_req.count = CNT_W'(FLOW_NUM_W);
      end
      ST_MVEL: begin
        mul_a = fmag_r;
        mul_b = gain_r;
      end
      ST_MLP: begin
        mul_a = dmag_r;
        mul_b = elapsed_r;
      end
      ST_DLP: begin
        div_req.start = 1'b1;
        div_req.rem0  = {1'b0, prod_r[63:32]};
        div_req.num   = {prod_r[31:0], 32'd0};
        div_req.den   = {13'd0, tau_r} + {1'b0, elapsed_r};
        div_req.count = CNT_W'(32);
      end
      default: begin
      end
    endcase
  end

  ofv_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  ofv_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .busy_r (div_busy),
    .done_r (div_done),
    .quot   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= GAIN_RESET;
      tau_r        <= TAU_RESET;
      win_r        <= WIN_RESET;
      start_r      <= 32'd0;
      started_r    <= 1'b0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      smooth_x_r   <= 32'd0;
      smooth_y_r   <= 32'd0;
      state_r      <= ST_IDLE;
      axis_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN: gain_r <= cfg_data;
          CFG_TAU:  tau_r  <= cfg_data[19:0];
          CFG_WIN:  win_r  <= cfg_data[19:0];
          default: begin
          end
        endcase
      end
      if (out_tvalid_r && out_tready && (state_r != ST_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            started_r <= 1'b1;
            start_r   <= close_c ? now_us : start_eff;
            sum_x_r   <= sum_x_nxt;
            sum_y_r   <= sum_y_nxt;
            if (close_c) begin
              elapsed_r <= elapsed_c;
              axis_r    <= 1'b0;
              state_r   <= ST_MFLOW;
            end
          end
        end
        ST_MFLOW: begin
          fneg_r  <= sum_sel[SUM_W-1];
          state_r <= ST_DFLOW;
        end
        ST_DFLOW: state_r <= ST_WFLOW;
        ST_WFLOW: begin
          if (div_done) begin
            fmag_r <= flow_mag_c;
            if (axis_r) begin
              flow_y_r <= fneg_r ? (~flow_mag_c + 1'b1) : flow_mag_c;
            end else begin
              flow_x_r <= fneg_r ? (~flow_mag_c + 1'b1) : flow_mag_c;
            end
            state_r <= ST_MVEL;
          end
        end
        ST_MVEL: state_r <= ST_DIFF;
        ST_DIFF: begin
          dneg_r  <= diff_c[32];
          dmag_r  <= diff_c[32] ? diff_neg_c[31:0] : diff_c[31:0];
          state_r <= ST_MLP;
        end
        ST_MLP: state_r <= ST_DLP;
        ST_DLP: state_r <= ST_WLP;
        ST_WLP: begin
          if (div_done) begin
            if (axis_r) begin
              smooth_y_r <= smooth_nxt;
              state_r    <= ST_OUT;
            end else begin
              smooth_x_r <= smooth_nxt;
              axis_r     <= 1'b1;
              state_r    <= ST_MFLOW;
            end
          end
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            sum_x_r      <= '0;
            sum_y_r      <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {flow_y_r, flow_x_r, smooth_y_r, smooth_x_r};
    end
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_WFLOW || state_r == ST_WLP))
    else $error("divider result arrived outside a wait state");

  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && close_c) |=> !in_tready)
    else $error("window close did not stop intake");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_OUT))
    else $error("result shown without finishing the sequence");

endmodule

// File: design/ofv_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on nothing outside itself.
module ofv_mul (
  input  logic        clk,
  input  logic [31:0] mul_a,
  input  logic [31:0] mul_b,
  output logic [63:0] prod_r
);

  logic [63:0] prod_nxt;

  assign prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: design/ofv_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ofv_pkg for the request struct and widths.
module ofv_div
  import ofv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             busy_r,
  output logic             done_r,
  output logic [DIV_W-1:0] quot
);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] qn_r, qn_nxt;
  logic [REM_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REM_W:0]   rem_sh;
  logic [REM_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, qn_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_nxt = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
  assign qn_nxt  = {qn_r[DIV_W-2:0], ge};
  assign quot    = qn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.count;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem0;
      qn_r  <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qn_r  <= qn_nxt;
    end
  end

endmodule
